// ===== sv/svgpn_pkg.sv =====
`default_nettype none

package svgpn_pkg;

    // default parameter values
    localparam int COORD_BITS_DEF = 32;
    localparam int MAX_ARGS_DEF   = 7;

    // token queue between the decode front and the execute back
    localparam int QUEUE_DEPTH = 4;

    // arguments of the longest command (arc)
    localparam int ARGS_USED = 7;

    // input token modes
    localparam logic [1:0] MODE_CMD = 2'd0;
    localparam logic [1:0] MODE_NUM = 2'd1;

    // decoded token kinds
    localparam logic [1:0] TK_CMD = 2'd0;
    localparam logic [1:0] TK_NUM = 2'd1;
    localparam logic [1:0] TK_BAD = 2'd2;

    // path operations
    localparam logic [3:0] OP_M = 4'd0;
    localparam logic [3:0] OP_L = 4'd1;
    localparam logic [3:0] OP_H = 4'd2;
    localparam logic [3:0] OP_V = 4'd3;
    localparam logic [3:0] OP_Q = 4'd4;
    localparam logic [3:0] OP_T = 4'd5;
    localparam logic [3:0] OP_C = 4'd6;
    localparam logic [3:0] OP_S = 4'd7;
    localparam logic [3:0] OP_A = 4'd8;
    localparam logic [3:0] OP_Z = 4'd9;

    // lower-case ascii letters and the case bit
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] LTR_M    = 8'h6d;
    localparam logic [7:0] LTR_L    = 8'h6c;
    localparam logic [7:0] LTR_H    = 8'h68;
    localparam logic [7:0] LTR_V    = 8'h76;
    localparam logic [7:0] LTR_Q    = 8'h71;
    localparam logic [7:0] LTR_T    = 8'h74;
    localparam logic [7:0] LTR_C    = 8'h63;
    localparam logic [7:0] LTR_S    = 8'h73;
    localparam logic [7:0] LTR_A    = 8'h61;
    localparam logic [7:0] LTR_Z    = 8'h7a;

    // element kinds
    localparam logic [2:0] EK_MOVE  = 3'd0;
    localparam logic [2:0] EK_LINE  = 3'd1;
    localparam logic [2:0] EK_QUAD  = 3'd2;
    localparam logic [2:0] EK_CUBIC = 3'd3;
    localparam logic [2:0] EK_CLOSE = 3'd4;
    localparam logic [2:0] EK_ARC   = 3'd5;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         command_letter;
        logic signed [31:0] number_value;
    } t_token_in;

    typedef struct packed {
        logic [2:0]         element_kind;
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic signed [31:0] point_c_x;
        logic signed [31:0] point_c_y;
        logic               halted;
    } t_element;

    // classified token as it sits in the queue
    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         op;
        logic               rel;
        logic [2:0]         nargs;
        logic signed [31:0] number;
    } t_token;

endpackage

`default_nettype wire

// ===== sv/svgpn_front.sv =====
`default_nettype none

module svgpn_front (
    input  wire logic                  i_valid,
    input  wire svgpn_pkg::t_token_in  i_token,
    input  wire logic                  i_q_full,
    output logic                       o_stall,
    output logic                       o_push,
    output svgpn_pkg::t_token          o_tok
);
    import svgpn_pkg::*;

    logic [7:0] w_lower;

    assign o_stall = i_q_full;
    assign o_push  = i_valid & ~i_q_full;
    assign w_lower = i_token.command_letter | CASE_BIT;

    always_comb begin
        o_tok.kind   = TK_BAD;
        o_tok.op     = OP_M;
        o_tok.rel    = i_token.command_letter[5];
        o_tok.nargs  = 3'd0;
        o_tok.number = i_token.number_value;
        unique case (i_token.mode)
            MODE_CMD: begin
                o_tok.kind = TK_CMD;
                unique case (w_lower)
                    LTR_M: begin o_tok.op = OP_M; o_tok.nargs = 3'd2; end
                    LTR_L: begin o_tok.op = OP_L; o_tok.nargs = 3'd2; end
                    LTR_T: begin o_tok.op = OP_T; o_tok.nargs = 3'd2; end
                    LTR_H: begin o_tok.op = OP_H; o_tok.nargs = 3'd1; end
                    LTR_V: begin o_tok.op = OP_V; o_tok.nargs = 3'd1; end
                    LTR_Q: begin o_tok.op = OP_Q; o_tok.nargs = 3'd4; end
                    LTR_S: begin o_tok.op = OP_S; o_tok.nargs = 3'd4; end
                    LTR_C: begin o_tok.op = OP_C; o_tok.nargs = 3'd6; end
                    LTR_A: begin o_tok.op = OP_A; o_tok.nargs = 3'd7; end
                    LTR_Z: begin o_tok.op = OP_Z; o_tok.nargs = 3'd0; end
                    default: o_tok.kind = TK_BAD;
                endcase
            end
            MODE_NUM: o_tok.kind = TK_NUM;
            default:  o_tok.kind = TK_BAD;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/svgpn_queue.sv =====
`default_nettype none

module svgpn_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire svgpn_pkg::t_token  i_data,
    output logic                    o_full,
    output logic                    o_valid,
    input  wire logic               i_pop,
    output svgpn_pkg::t_token       o_data
);
    import svgpn_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_token             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rptr];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_do_push & ~w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (~w_do_push & w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/svgpn_exec.sv =====
`default_nettype none

module svgpn_exec #(
    parameter int COORD_BITS = svgpn_pkg::COORD_BITS_DEF,
    parameter int MAX_ARGS   = svgpn_pkg::MAX_ARGS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tok_valid,
    input  wire svgpn_pkg::t_token  i_tok,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output svgpn_pkg::t_element     o_element
);
    import svgpn_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = $clog2(MAX_ARGS);
    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    typedef logic signed [CB-1:0] t_coord;

    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        logic signed [CB:0] s;
        s = {a[CB-1], a} + {b[CB-1], b};
        if (s[CB] != s[CB-1]) begin
            sat_add = s[CB] ? C_MIN : C_MAX;
        end else begin
            sat_add = s[CB-1:0];
        end
    endfunction

    function automatic t_coord sat_sub(input t_coord a, input t_coord b);
        logic signed [CB:0] s;
        s = {a[CB-1], a} - {b[CB-1], b};
        if (s[CB] != s[CB-1]) begin
            sat_sub = s[CB] ? C_MIN : C_MAX;
        end else begin
            sat_sub = s[CB-1:0];
        end
    endfunction

    // state
    logic               r_has_cmd, n_has_cmd;
    logic [3:0]         r_op, n_op;
    logic               r_rel, n_rel;
    logic [2:0]         r_nexp, n_nexp;
    logic [CNT_W-1:0]   r_ngot, n_ngot;
    t_coord             r_buf [MAX_ARGS];
    t_coord             r_start_x, n_start_x, r_start_y, n_start_y;
    t_coord             r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic signed [CB-1:0] r_ctl_x, n_ctl_x, r_ctl_y, n_ctl_y;
    logic               r_stopped, n_stopped;
    logic               r_out_valid, n_out_valid;
    t_element           r_out;

    // working values
    t_coord     w_num;
    t_coord     w_arg [ARGS_USED];
    t_coord     w_ox, w_oy;
    t_coord     w_s0x, w_s0y, w_s1x, w_s1y, w_s2x, w_s2y, w_ex, w_ey, w_vy;
    t_coord     w_rfx, w_rfy;
    t_coord     w_ax, w_ay, w_bx, w_by, w_cx, w_cy, w_flags;
    logic [2:0] w_kind;
    logic       w_halt, w_res, w_buf_we;
    logic [CNT_W-1:0] w_ngot_inc;

    // input number saturated to the coordinate width
    generate
        if (CB >= 32) begin : g_wide_num
            assign w_num = CB'(i_tok.number);
        end else begin : g_narrow_num
            logic w_fits;
            assign w_fits = (i_tok.number[31:CB-1] == {(33-CB){1'b0}}) ||
                            (i_tok.number[31:CB-1] == {(33-CB){1'b1}});
            assign w_num  = w_fits ? i_tok.number[CB-1:0] :
                            (i_tok.number[31] ? C_MIN : C_MAX);
        end
    endgenerate

    assign o_pop      = i_tok_valid & (~r_out_valid | ~i_stall);
    assign w_ngot_inc = r_ngot + 1'b1;

    // newest argument bypasses the buffer
    always_comb begin
        for (int k = 0; k < ARGS_USED; k++) begin
            w_arg[k] = (r_ngot == CNT_W'(k)) ? w_num : r_buf[k];
        end
    end

    assign w_ox  = r_rel ? r_cur_x : '0;
    assign w_oy  = r_rel ? r_cur_y : '0;
    assign w_s0x = sat_add(w_arg[0], w_ox);
    assign w_s0y = sat_add(w_arg[1], w_oy);
    assign w_s1x = sat_add(w_arg[2], w_ox);
    assign w_s1y = sat_add(w_arg[3], w_oy);
    assign w_s2x = sat_add(w_arg[4], w_ox);
    assign w_s2y = sat_add(w_arg[5], w_oy);
    assign w_ex  = sat_add(w_arg[5], w_ox);
    assign w_ey  = sat_add(w_arg[6], w_oy);
    assign w_vy  = sat_add(w_arg[0], w_oy);
    assign w_rfx = sat_add(r_cur_x, sat_sub(r_cur_x, r_ctl_x));
    assign w_rfy = sat_add(r_cur_y, sat_sub(r_cur_y, r_ctl_y));

    always_comb begin
        w_flags      = '0;
        w_flags[1:0] = {w_arg[4] != '0, w_arg[3] != '0};
    end

    always_comb begin
        n_has_cmd   = r_has_cmd;
        n_op        = r_op;
        n_rel       = r_rel;
        n_nexp      = r_nexp;
        n_ngot      = r_ngot;
        n_start_x   = r_start_x;
        n_start_y   = r_start_y;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_ctl_x     = r_ctl_x;
        n_ctl_y     = r_ctl_y;
        n_stopped   = r_stopped;
        w_kind      = EK_MOVE;
        w_ax        = '0;
        w_ay        = '0;
        w_bx        = '0;
        w_by        = '0;
        w_cx        = '0;
        w_cy        = '0;
        w_halt      = 1'b0;
        w_res       = 1'b0;
        w_buf_we    = 1'b0;

        if (o_pop && !r_stopped) begin
            case (i_tok.kind)
                TK_CMD: begin
                    if (i_tok.op == OP_Z) begin
                        n_cur_x = r_start_x;
                        n_cur_y = r_start_y;
                        n_ctl_x = r_start_x;
                        n_ctl_y = r_start_y;
                        n_ngot  = '0;
                        w_kind  = EK_CLOSE;
                        w_res   = 1'b1;
                    end else begin
                        n_has_cmd = 1'b1;
                        n_op      = i_tok.op;
                        n_rel     = i_tok.rel;
                        n_nexp    = i_tok.nargs;
                        n_ngot    = '0;
                    end
                end
                TK_NUM: begin
                    if (!r_has_cmd || r_ngot >= CNT_W'(MAX_ARGS)) begin
                        w_halt = 1'b1;
                    end else begin
                        w_buf_we = 1'b1;
                        if (w_ngot_inc < CNT_W'(r_nexp)) begin
                            n_ngot = w_ngot_inc;
                        end else begin
                            n_ngot = '0;
                            w_res  = 1'b1;
                            unique case (r_op) inside
                                OP_M, OP_L, OP_H, OP_V: begin
                                    w_kind = (r_op == OP_M) ? EK_MOVE : EK_LINE;
                                    w_ax   = (r_op == OP_V) ? r_cur_x : w_s0x;
                                    w_ay   = (r_op == OP_H) ? r_cur_y :
                                             (r_op == OP_V) ? w_vy : w_s0y;
                                    n_cur_x = w_ax;
                                    n_cur_y = w_ay;
                                    n_ctl_x = w_ax;
                                    n_ctl_y = w_ay;
                                    if (r_op == OP_M) begin
                                        // further pairs after a move are lines
                                        n_start_x = w_ax;
                                        n_start_y = w_ay;
                                        n_op      = OP_L;
                                    end
                                end
                                OP_Q, OP_T: begin
                                    w_kind  = EK_QUAD;
                                    w_ax    = (r_op == OP_Q) ? w_s0x : w_rfx;
                                    w_ay    = (r_op == OP_Q) ? w_s0y : w_rfy;
                                    w_bx    = (r_op == OP_Q) ? w_s1x : w_s0x;
                                    w_by    = (r_op == OP_Q) ? w_s1y : w_s0y;
                                    n_cur_x = w_bx;
                                    n_cur_y = w_by;
                                    n_ctl_x = w_ax;
                                    n_ctl_y = w_ay;
                                end
                                OP_C, OP_S: begin
                                    w_kind  = EK_CUBIC;
                                    w_ax    = (r_op == OP_C) ? w_s0x : w_rfx;
                                    w_ay    = (r_op == OP_C) ? w_s0y : w_rfy;
                                    w_bx    = (r_op == OP_C) ? w_s1x : w_s0x;
                                    w_by    = (r_op == OP_C) ? w_s1y : w_s0y;
                                    w_cx    = (r_op == OP_C) ? w_s2x : w_s1x;
                                    w_cy    = (r_op == OP_C) ? w_s2y : w_s1y;
                                    n_cur_x = w_cx;
                                    n_cur_y = w_cy;
                                    n_ctl_x = w_bx;
                                    n_ctl_y = w_by;
                                end
                                OP_A: begin
                                    w_kind  = EK_ARC;
                                    w_ax    = w_arg[0];
                                    w_ay    = w_arg[1];
                                    w_bx    = w_arg[2];
                                    w_by    = w_flags;
                                    w_cx    = w_ex;
                                    w_cy    = w_ey;
                                    n_cur_x = w_ex;
                                    n_cur_y = w_ey;
                                    n_ctl_x = w_ex;
                                    n_ctl_y = w_ey;
                                end
                                default: begin
                                    w_res  = 1'b0;
                                    w_halt = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                default: w_halt = 1'b1;
            endcase
        end

        if (w_halt) begin
            n_stopped = 1'b1;
            w_res     = 1'b1;
            w_kind    = EK_MOVE;
            w_ax      = '0;
            w_ay      = '0;
            w_bx      = '0;
            w_by      = '0;
            w_cx      = '0;
            w_cy      = '0;
        end

        if (w_res) begin
            n_out_valid = 1'b1;
        end else if (~i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_cmd   <= 1'b0;
            r_op        <= OP_M;
            r_rel       <= 1'b0;
            r_nexp      <= '0;
            r_ngot      <= '0;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_ctl_x     <= '0;
            r_ctl_y     <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_has_cmd   <= n_has_cmd;
            r_op        <= n_op;
            r_rel       <= n_rel;
            r_nexp      <= n_nexp;
            r_ngot      <= n_ngot;
            r_start_x   <= n_start_x;
            r_start_y   <= n_start_y;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_ctl_x     <= n_ctl_x;
            r_ctl_y     <= n_ctl_y;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_buf[r_ngot[IDX_W-1:0]] <= w_num;
        end
        if (w_res) begin
            r_out.element_kind <= w_kind;
            r_out.point_a_x    <= 32'(w_ax);
            r_out.point_a_y    <= 32'(w_ay);
            r_out.point_b_x    <= 32'(w_bx);
            r_out.point_b_y    <= 32'(w_by);
            r_out.point_c_x    <= 32'(w_cx);
            r_out.point_c_y    <= 32'(w_cy);
            r_out.halted       <= w_halt;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_element = r_out;

endmodule

`default_nettype wire

// ===== sv/svg_path_command_normalizer.sv =====
// svg path command normalizer
// input channel: one pre-lexed path token per beat on i_token (command letter,
// q16.16 number or bad token), handshake i_valid / o_stall.
// output channel: one absolute path element per beat on o_element
// (move, line, quadratic, cubic, close or arc), handshake o_valid / i_stall.
// tokens that only select a command or gather an argument give no element.
// a decode front classifies each token into a short token queue; the execute
// back pops one token per cycle unless stalled and updates the path state in
// one step. throughput: one token per cycle while the output is not stalled.
// each token is registered in the queue and its element in the output
// register, which holds it while the output is stalled.
// when i_stall holds on a valid element, the output register keeps it, the
// back stops popping, the queue fills, and o_stall rises once it is full.
// a bad token, an unknown letter or a number before any command gives one
// element with halted set; every later token is then taken and dropped.
// reset (synchronous, i_rst_n low) clears the queue, the output valid and all
// path state; no clearing pass is needed, tokens are taken right after.
`default_nettype none

module svg_path_command_normalizer #(
    parameter int COORD_BITS = svgpn_pkg::COORD_BITS_DEF,
    parameter int MAX_ARGS   = svgpn_pkg::MAX_ARGS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire svgpn_pkg::t_token_in  i_token,
    output logic                       o_stall,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output svgpn_pkg::t_element        o_element
);
    import svgpn_pkg::*;

    t_token w_push_tok;
    t_token w_pop_tok;
    logic   w_push, w_q_full, w_q_valid, w_pop;

    svgpn_front u_front (
        .i_valid  (i_valid),
        .i_token  (i_token),
        .i_q_full (w_q_full),
        .o_stall  (o_stall),
        .o_push   (w_push),
        .o_tok    (w_push_tok)
    );

    svgpn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_tok),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_pop_tok)
    );

    svgpn_exec #(
        .COORD_BITS (COORD_BITS),
        .MAX_ARGS   (MAX_ARGS)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_q_valid),
        .i_tok       (w_pop_tok),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_element   (o_element)
    );

endmodule

`default_nettype wire

// ===== sv/svgpn_checker.sv =====
`default_nettype none

module svgpn_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire svgpn_pkg::t_token_in  i_token,
    input  wire logic                  o_stall,
    input  wire logic                  o_valid,
    input  wire logic                  i_stall,
    input  wire svgpn_pkg::t_element   o_element
);
    import svgpn_pkg::*;

    // nothing comes out of a reset cycle
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // halt beat carries a blank move
    a_halt_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_element.halted) |->
        (o_element.element_kind == EK_MOVE && o_element.point_a_x == 0 &&
         o_element.point_a_y == 0 && o_element.point_b_x == 0 &&
         o_element.point_b_y == 0 && o_element.point_c_x == 0 &&
         o_element.point_c_y == 0))
        else $error("halt beat not blank");

    // once halted, no further elements
    a_halt_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_element.halted) |=> !o_valid)
        else $error("element after halt");

    // close is not halted and carries no a or c points
    a_close_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_element.element_kind == EK_CLOSE) |->
        (!o_element.halted && o_element.point_a_x == 0 &&
         o_element.point_a_y == 0 && o_element.point_c_x == 0 &&
         o_element.point_c_y == 0))
        else $error("close beat carries points");

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_element)))
        else $error("stalled beat changed");

endmodule

bind svg_path_command_normalizer svgpn_checker u_svgpn_checker (.*);

`default_nettype wire

// ===== tb/svg_path_command_normalizer_tb.sv =====
`timescale 1ns / 100ps

module svg_path_command_normalizer_tb;
    import svgpn_pkg::*;

    typedef logic signed [31:0] coord_t;

    localparam coord_t COORD_MAX = 32'sh7fff_ffff;
    localparam coord_t COORD_MIN = 32'sh8000_0000;
    localparam logic [1:0] MODE_BAD    = 2'd2;
    localparam logic [1:0] MODE_BAD_HI = 2'd3;
    localparam int RANDOM_TOKENS = 1900;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SHOWN_ERRORS  = 10;

    // path state tracker: predicts the elements that the accepted tokens give and
    // checks the elements that come out against them in order
    class svgpn_tracker;
        t_element   expected_q[$];
        logic [7:0] active_cmd;
        int         arg_want;
        int         arg_have;
        coord_t     arg_buf[ARGS_USED];
        coord_t     start_x, start_y;
        coord_t     cur_x, cur_y;
        coord_t     ctl_x, ctl_y;
        bit         stopped;
        int         errors;

        function new();
            active_cmd = '0;
            arg_want = 0;
            arg_have = 0;
            start_x = '0;
            start_y = '0;
            cur_x = '0;
            cur_y = '0;
            ctl_x = '0;
            ctl_y = '0;
            stopped = 1'b0;
            errors = 0;
        endfunction

        static function int arg_count(logic [7:0] ltr);
            case (ltr | CASE_BIT)
                LTR_M, LTR_L, LTR_T: return 2;
                LTR_H, LTR_V:        return 1;
                LTR_Q, LTR_S:        return 4;
                LTR_C:               return 6;
                LTR_A:               return 7;
                default:             return 0;
            endcase
        endfunction

        function coord_t clamp(longint s);
            if (s > longint'(COORD_MAX))
                return COORD_MAX;
            if (s < longint'(COORD_MIN))
                return COORD_MIN;
            return coord_t'(s);
        endfunction

        function coord_t offset(coord_t a, coord_t o);
            return clamp(longint'(a) + o);
        endfunction

        // implied control point of s and t
        function coord_t reflect(coord_t cur, coord_t ctl);
            return clamp(longint'(cur) + clamp(longint'(cur) - ctl));
        endfunction

        function void place(coord_t x, coord_t y);
            cur_x = x;
            cur_y = y;
            ctl_x = x;
            ctl_y = y;
        endfunction

        function void expect_element(logic [2:0] kind, coord_t ax, coord_t ay, coord_t bx,
                                     coord_t by, coord_t cx, coord_t cy, logic h);
            t_element e;
            e.element_kind = kind;
            e.point_a_x = ax;
            e.point_a_y = ay;
            e.point_b_x = bx;
            e.point_b_y = by;
            e.point_c_x = cx;
            e.point_c_y = cy;
            e.halted = h;
            expected_q.push_back(e);
        endfunction

        function void halt_parsing();
            stopped = 1'b1;
            expect_element(EK_MOVE, '0, '0, '0, '0, '0, '0, 1'b1);
        endfunction

        function void note_token(t_token_in tok);
            logic [7:0] ltr;
            bit         rel;
            coord_t     ox, oy, x, y, c0x, c0y, c1x, c1y;
            if (stopped)
                return;
            if (tok.mode == MODE_CMD) begin
                ltr = tok.command_letter;
                if ((ltr | CASE_BIT) == LTR_Z) begin
                    place(start_x, start_y);
                    arg_have = 0;
                    expect_element(EK_CLOSE, '0, '0, '0, '0, '0, '0, 1'b0);
                end else if (arg_count(ltr) == 0) begin
                    halt_parsing();
                end else begin
                    active_cmd = ltr;
                    arg_want = arg_count(ltr);
                    arg_have = 0;
                end
                return;
            end
            if (tok.mode != MODE_NUM || active_cmd == 0 || arg_want == 0 ||
                arg_have >= MAX_ARGS_DEF) begin
                halt_parsing();
                return;
            end
            arg_buf[arg_have] = tok.number_value;
            arg_have++;
            if (arg_have < arg_want)
                return;
            arg_have = 0;

            rel = (active_cmd & CASE_BIT) != 0;
            ox = rel ? cur_x : 32'sd0;
            oy = rel ? cur_y : 32'sd0;
            case (active_cmd | CASE_BIT)
                LTR_M: begin
                    x = offset(arg_buf[0], ox);
                    y = offset(arg_buf[1], oy);
                    start_x = x;
                    start_y = y;
                    place(x, y);
                    // further pairs after a move are lines
                    active_cmd = rel ? LTR_L : (LTR_L & ~CASE_BIT);
                    expect_element(EK_MOVE, x, y, '0, '0, '0, '0, 1'b0);
                end
                LTR_L, LTR_H, LTR_V: begin
                    x = offset(arg_buf[0], ox);
                    y = offset(arg_buf[1], oy);
                    if ((active_cmd | CASE_BIT) == LTR_H)
                        y = cur_y;
                    if ((active_cmd | CASE_BIT) == LTR_V) begin
                        x = cur_x;
                        y = offset(arg_buf[0], oy);
                    end
                    place(x, y);
                    expect_element(EK_LINE, x, y, '0, '0, '0, '0, 1'b0);
                end
                LTR_Q, LTR_T: begin
                    if ((active_cmd | CASE_BIT) == LTR_Q) begin
                        c0x = offset(arg_buf[0], ox);
                        c0y = offset(arg_buf[1], oy);
                        x = offset(arg_buf[2], ox);
                        y = offset(arg_buf[3], oy);
                    end else begin
                        c0x = reflect(cur_x, ctl_x);
                        c0y = reflect(cur_y, ctl_y);
                        x = offset(arg_buf[0], ox);
                        y = offset(arg_buf[1], oy);
                    end
                    cur_x = x;
                    cur_y = y;
                    ctl_x = c0x;
                    ctl_y = c0y;
                    expect_element(EK_QUAD, c0x, c0y, x, y, '0, '0, 1'b0);
                end
                LTR_C, LTR_S: begin
                    if ((active_cmd | CASE_BIT) == LTR_C) begin
                        c0x = offset(arg_buf[0], ox);
                        c0y = offset(arg_buf[1], oy);
                        c1x = offset(arg_buf[2], ox);
                        c1y = offset(arg_buf[3], oy);
                        x = offset(arg_buf[4], ox);
                        y = offset(arg_buf[5], oy);
                    end else begin
                        c0x = reflect(cur_x, ctl_x);
                        c0y = reflect(cur_y, ctl_y);
                        c1x = offset(arg_buf[0], ox);
                        c1y = offset(arg_buf[1], oy);
                        x = offset(arg_buf[2], ox);
                        y = offset(arg_buf[3], oy);
                    end
                    cur_x = x;
                    cur_y = y;
                    ctl_x = c1x;
                    ctl_y = c1y;
                    expect_element(EK_CUBIC, c0x, c0y, c1x, c1y, x, y, 1'b0);
                end
                LTR_A: begin
                    x = offset(arg_buf[5], ox);
                    y = offset(arg_buf[6], oy);
                    place(x, y);
                    expect_element(EK_ARC, arg_buf[0], arg_buf[1], arg_buf[2],
                                   {30'd0, arg_buf[4] != 0, arg_buf[3] != 0}, x, y, 1'b0);
                end
                default: halt_parsing();
            endcase
        endfunction

        function string describe(t_element e);
            return $sformatf("kind %0d a (%0d, %0d) b (%0d, %0d) c (%0d, %0d) halted %0b",
                             e.element_kind, e.point_a_x, e.point_a_y, e.point_b_x,
                             e.point_b_y, e.point_c_x, e.point_c_y, e.halted);
        endfunction

        function void check_element(t_element got);
            t_element want;
            bit       bad;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("unexpected element: %s", describe(got));
                return;
            end
            want = expected_q.pop_front();
            bad = got.element_kind !== want.element_kind ||
                  got.point_a_x !== want.point_a_x || got.point_a_y !== want.point_a_y ||
                  got.point_b_x !== want.point_b_x || got.point_b_y !== want.point_b_y ||
                  got.point_c_x !== want.point_c_x || got.point_c_y !== want.point_c_y ||
                  got.halted !== want.halted;
            if (bad) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("element mismatch at %0t\n  expected %s\n  actual   %s",
                             $realtime, describe(want), describe(got));
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_token_in i_token = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_element  o_element;

    bit           calm = 1'b0;
    svgpn_tracker tracker;
    t_token_in    token_script[$];

    svg_path_command_normalizer dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_token   (i_token),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_element (o_element)
    );

    always begin
        #5;
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
    end

    function automatic t_token_in letter_token(logic [7:0] ltr);
        t_token_in tok;
        tok.mode = MODE_CMD;
        tok.command_letter = ltr;
        tok.number_value = $urandom;
        return tok;
    endfunction

    function automatic t_token_in number_token(coord_t v);
        t_token_in tok;
        tok.mode = MODE_NUM;
        tok.command_letter = 8'($urandom);
        tok.number_value = v;
        return tok;
    endfunction

    function automatic coord_t pick_value();
        case ($urandom_range(9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return coord_t'($urandom);
            3:       return coord_t'(int'($urandom_range(6)) - 3);
            default: return coord_t'(int'($urandom_range(1 << 27)) - (1 << 26));
        endcase
    endfunction

    function automatic logic [7:0] random_path_letter();
        logic [7:0] ltr;
        case ($urandom_range(8))
            0:       ltr = LTR_M;
            1:       ltr = LTR_L;
            2:       ltr = LTR_H;
            3:       ltr = LTR_V;
            4:       ltr = LTR_Q;
            5:       ltr = LTR_T;
            6:       ltr = LTR_C;
            7:       ltr = LTR_S;
            default: ltr = LTR_A;
        endcase
        if ($urandom_range(1))
            ltr = ltr & ~CASE_BIT;
        return ltr;
    endfunction

    task automatic drive_token(input t_token_in tok);
        while (!calm && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_token <= tok;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        tracker.note_token(tok);
    endtask

    // output side: check each element beat, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_element(o_element);
        i_stall <= !calm && ($urandom_range(99) < 37);
    end

    initial begin
        int         quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("** svg_path_command_normalizer: FAILED **");
        $finish;
    end

    initial begin
        int         directed_len;
        int         pick;
        int         n;
        logic [7:0] ltr;
        t_token_in  tok;
        tracker = new();

        // close before any command, then a relative move to the corners
        token_script.push_back(letter_token(LTR_Z & ~CASE_BIT));
        token_script.push_back(letter_token(LTR_M));
        token_script.push_back(number_token(COORD_MAX));
        token_script.push_back(number_token(COORD_MIN));
        // second pair of the move is a saturating relative line
        token_script.push_back(number_token(COORD_MAX));
        token_script.push_back(number_token(COORD_MAX));
        token_script.push_back(letter_token(LTR_Z));
        // smooth cubic right after a close reflects about the current point
        token_script.push_back(letter_token(LTR_S & ~CASE_BIT));
        token_script.push_back(number_token(coord_t'(1 << 16)));
        token_script.push_back(number_token(coord_t'(2 << 16)));
        token_script.push_back(number_token(COORD_MIN));
        token_script.push_back(number_token(COORD_MAX));
        // smooth quadratic after a cubic, reflection saturates
        token_script.push_back(letter_token(LTR_T & ~CASE_BIT));
        token_script.push_back(number_token(coord_t'(0)));
        token_script.push_back(number_token(coord_t'(0)));
        // partial cubic dropped by the next letter
        token_script.push_back(letter_token(LTR_C & ~CASE_BIT));
        token_script.push_back(number_token(coord_t'(3 << 16)));
        token_script.push_back(letter_token(LTR_A));
        token_script.push_back(number_token(coord_t'(5 << 16)));
        token_script.push_back(number_token(coord_t'(3 << 16)));
        token_script.push_back(number_token(coord_t'(30 << 16)));
        token_script.push_back(number_token(coord_t'(0)));
        token_script.push_back(number_token(coord_t'(7)));
        token_script.push_back(number_token(coord_t'(-65536)));
        token_script.push_back(number_token(coord_t'(65536)));
        directed_len = token_script.size();

        while (token_script.size() < directed_len + RANDOM_TOKENS) begin
            pick = $urandom_range(99);
            ltr = random_path_letter();
            n = svgpn_tracker::arg_count(ltr);
            if (pick < 78) begin
                token_script.push_back(letter_token(ltr));
                repeat ($urandom_range(3, 1)) begin
                    for (int k = 0; k < n; k++) begin
                        if ((ltr | CASE_BIT) == LTR_A && (k == 3 || k == 4) &&
                            $urandom_range(3) != 0)
                            token_script.push_back(number_token(coord_t'($urandom_range(1))));
                        else
                            token_script.push_back(number_token(pick_value()));
                    end
                end
            end else if (pick < 88) begin
                // command cut short
                token_script.push_back(letter_token(ltr));
                repeat ($urandom_range(n - 1))
                    token_script.push_back(number_token(pick_value()));
            end else if (pick < 94) begin
                token_script.push_back(letter_token($urandom_range(1) ? LTR_Z
                                                                      : LTR_Z & ~CASE_BIT));
            end else begin
                repeat ($urandom_range(3, 1))
                    token_script.push_back(number_token(pick_value()));
            end
        end

        // one stop cause at the end, then tokens that must be dropped
        case ($urandom_range(2))
            0: begin
                tok = number_token(pick_value());
                tok.mode = MODE_BAD;
            end
            1: begin
                tok = letter_token(random_path_letter());
                tok.mode = MODE_BAD_HI;
            end
            default: begin
                do
                    ltr = 8'($urandom);
                while (svgpn_tracker::arg_count(ltr) != 0 || (ltr | CASE_BIT) == LTR_Z);
                tok = letter_token(ltr);
            end
        endcase
        token_script.push_back(tok);
        repeat (12) begin
            tok.mode = 2'($urandom);
            tok.command_letter = 8'($urandom);
            tok.number_value = $urandom;
            token_script.push_back(tok);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (token_script[k]) begin
            calm <= (k >= directed_len + 700 && k < directed_len + 1000);
            drive_token(token_script[k]);
        end
        i_valid <= 1'b0;

        while (tracker.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.expected_q.size() == 0)
            $display("** svg_path_command_normalizer: PASSED **");
        else
            $display("** svg_path_command_normalizer: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/svgpn_pkg.sv
sv/svgpn_front.sv
sv/svgpn_queue.sv
sv/svgpn_exec.sv
sv/svg_path_command_normalizer.sv
sv/svgpn_checker.sv
tb/svg_path_command_normalizer_tb.sv
